@@ src/vpce_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package vpce_pkg;

  // Default geometry
  localparam int COORD_BITS_DEF = 23;
  localparam int SCALE_FRAC_DEF = 10;

  // Scale register
  localparam int                 SCALE_W     = 11;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 11'd800;

  // Number coding: magnitudes saturate to 22 bits
  localparam int               MAG_W   = 22;
  localparam logic [MAG_W-1:0] MAG_MAX = 22'h3F_FFFF;

  // Numbers carried per command, command queue depth (power of two)
  localparam int NUM_SLOTS   = 4;
  localparam int QUEUE_DEPTH = 4;

  // Request kinds
  localparam logic [2:0] REQ_MOVE       = 3'd0;
  localparam logic [2:0] REQ_DRAW       = 3'd1;
  localparam logic [2:0] REQ_BEGIN_LINE = 3'd2;
  localparam logic [2:0] REQ_BEGIN_POLY = 3'd3;
  localparam logic [2:0] REQ_POINT      = 3'd4;
  localparam logic [2:0] REQ_END        = 3'd5;
  localparam logic [2:0] REQ_PEN        = 3'd6;

  // Command stream bytes
  localparam logic [7:0] BYTE_LINE    = 8'h31;
  localparam logic [7:0] BYTE_POLY    = 8'h32;
  localparam logic [7:0] BYTE_PEN     = 8'h49;
  localparam logic [7:0] BYTE_TERM    = 8'h1e;
  localparam logic [7:0] BYTE_PREFIX  = 8'h40;
  localparam logic [7:0] BYTE_NUM_POS = 8'h30;
  localparam logic [7:0] BYTE_NUM_NEG = 8'h20;

  // Where the byte sequencer stands within one command
  typedef enum logic [1:0] {
    PH_HDR,
    PH_NUM,
    PH_TRL
  } phase_t;

  // One number, already saturated: sign and magnitude
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } num_t;

  // One command as queued between front and back
  typedef struct packed {
    phase_t                  first;
    logic [7:0]              hdr;
    logic [2:0]              num_cnt;
    num_t [NUM_SLOTS-1:0]    nums;
    logic                    has_trl;
  } cmd_t;

  // Gray pen class to pen command code
  function automatic logic signed [7:0] pen_code(input logic [2:0] cls);
    logic signed [7:0] c;
    unique case (cls)
      3'd0:    c = -8'sd29;
      3'd1:    c = -8'sd30;
      3'd2:    c = -8'sd31;
      3'd3:    c = -8'sd32;
      3'd4:    c = -8'sd41;
      3'd5:    c = -8'sd33;
      3'd6:    c = -8'sd34;
      default: c = -8'sd35;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ src/vpce_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module vpce_front #(
  parameter int COORD_BITS      = vpce_pkg::COORD_BITS_DEF,
  parameter int SCALE_FRAC_BITS = vpce_pkg::SCALE_FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [vpce_pkg::SCALE_W-1:0]   cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_req,
  input  logic signed [COORD_BITS-1:0]   in_x,
  input  logic signed [COORD_BITS-1:0]   in_y,
  input  logic [2:0]                     in_pen,
  output logic                           q_push,
  output vpce_pkg::cmd_t                 q_data,
  input  logic                           q_full
);
  import vpce_pkg::*;

  localparam int PW = COORD_BITS + SCALE_W + 1;
  localparam int NW = COORD_BITS + 1;
  localparam int SW = ((NW > MAG_W + 2) ? NW : MAG_W + 2) + 1;

  localparam logic signed [PW-1:0] RND   = PW'((1 << SCALE_FRAC_BITS) - 1);
  localparam logic signed [PW-1:0] Q_MAX = {{(PW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [PW-1:0] Q_MIN = {{(PW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [SW-1:0] MAG_LIM = {{(SW-MAG_W){1'b0}}, MAG_MAX};

  // Drop fraction toward zero, clamp to the coordinate range
  function automatic logic signed [COORD_BITS-1:0] scale_fix(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] adj;
    logic signed [PW-1:0] q;
    logic signed [PW-1:0] c;
    adj = p[PW-1] ? p + RND : p;
    q   = adj >>> SCALE_FRAC_BITS;
    if (q > Q_MAX) begin
      c = Q_MAX;
    end else if (q < Q_MIN) begin
      c = Q_MIN;
    end else begin
      c = q;
    end
    return c[COORD_BITS-1:0];
  endfunction

  // Saturate to the codable magnitude, split sign and magnitude
  function automatic num_t sat_num(input logic signed [NW-1:0] v);
    logic signed [SW-1:0] w;
    logic signed [SW-1:0] a;
    num_t                 r;
    w     = SW'(v);
    a     = w[SW-1] ? -w : w;
    r.neg = w[SW-1];
    if (a > MAG_LIM) begin
      r.mag = MAG_MAX;
    end else begin
      r.mag = a[MAG_W-1:0];
    end
    return r;
  endfunction

  logic                         adv;
  logic [SCALE_W-1:0]           scale_r;

  logic                         s1_v_r;
  logic [2:0]                   s1_req_r;
  logic signed [PW-1:0]         s1_px_r;
  logic signed [PW-1:0]         s1_py_r;
  logic [2:0]                   s1_pen_r;

  logic                         s2_v_r;
  logic [2:0]                   s2_req_r;
  logic signed [COORD_BITS-1:0] s2_x_r;
  logic signed [COORD_BITS-1:0] s2_y_r;
  logic [2:0]                   s2_pen_r;

  logic signed [COORD_BITS-1:0] pos_x_r, pos_x_nxt;
  logic signed [COORD_BITS-1:0] pos_y_r, pos_y_nxt;
  logic [2:0]                   cls_r, cls_nxt;
  logic                         open_r, open_nxt;
  logic                         vis_r, vis_nxt;

  logic                         s3_v_r, s3_v_nxt;
  phase_t                       s3_first_r, s3_first_nxt;
  logic [7:0]                   s3_hdr_r, s3_hdr_nxt;
  logic [2:0]                   s3_cnt_r, s3_cnt_nxt;
  logic                         s3_trl_r, s3_trl_nxt;
  logic signed [NW-1:0]         s3_val_r [NUM_SLOTS];
  logic signed [NW-1:0]         s3_val_nxt [NUM_SLOTS];

  logic signed [NW-1:0]         px_ext, py_ext, sx_ext, sy_ext;
  logic signed [NW-1:0]         dx, dy;

  // Whole front moves as one; it holds only when a command cannot enter the queue
  assign adv      = !(s3_v_r && q_full);
  assign in_ready = adv;

  // Scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  // Stage 1: scale multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req_r <= in_req;
      s1_px_r  <= in_x * $signed({1'b0, scale_r});
      s1_py_r  <= in_y * $signed({1'b0, scale_r});
      s1_pen_r <= in_pen;
    end
  end

  // Stage 2: truncate and clamp
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_req_r <= s1_req_r;
      s2_x_r   <= scale_fix(s1_px_r);
      s2_y_r   <= scale_fix(s1_py_r);
      s2_pen_r <= s1_pen_r;
    end
  end

  // Stage 3: offsets from the tracked pen position
  assign px_ext = NW'(pos_x_r);
  assign py_ext = NW'(pos_y_r);
  assign sx_ext = NW'(s2_x_r);
  assign sy_ext = NW'(s2_y_r);
  assign dx     = sx_ext - px_ext;
  assign dy     = sy_ext - py_ext;

  // Stage 3: classify the event, update pen state, build the command
  always_comb begin
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    cls_nxt      = cls_r;
    open_nxt     = open_r;
    vis_nxt      = vis_r;
    s3_v_nxt     = 1'b0;
    s3_first_nxt = PH_HDR;
    s3_hdr_nxt   = BYTE_LINE;
    s3_cnt_nxt   = 3'd0;
    s3_trl_nxt   = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      s3_val_nxt[i] = '0;
    end
    if (s2_v_r) begin
      if (open_r) begin
        case (s2_req_r)
          REQ_POINT: begin
            pos_x_nxt = s2_x_r;
            pos_y_nxt = s2_y_r;
            if (vis_r) begin
              s3_v_nxt      = 1'b1;
              s3_first_nxt  = PH_NUM;
              s3_cnt_nxt    = 3'd2;
              s3_val_nxt[0] = dx;
              s3_val_nxt[1] = dy;
            end
          end
          REQ_END: begin
            open_nxt = 1'b0;
            vis_nxt  = 1'b0;
            if (vis_r) begin
              s3_v_nxt     = 1'b1;
              s3_first_nxt = PH_TRL;
              s3_trl_nxt   = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end else begin
        case (s2_req_r) inside
          REQ_MOVE: begin
            pos_x_nxt = s2_x_r;
            pos_y_nxt = s2_y_r;
          end
          REQ_DRAW: begin
            pos_x_nxt = s2_x_r;
            pos_y_nxt = s2_y_r;
            if (cls_r != 3'd0) begin
              s3_v_nxt      = 1'b1;
              s3_hdr_nxt    = BYTE_LINE;
              s3_cnt_nxt    = 3'd4;
              s3_val_nxt[0] = px_ext;
              s3_val_nxt[1] = py_ext;
              s3_val_nxt[2] = dx;
              s3_val_nxt[3] = dy;
              s3_trl_nxt    = 1'b1;
            end
          end
          REQ_BEGIN_LINE, REQ_BEGIN_POLY: begin
            pos_x_nxt = s2_x_r;
            pos_y_nxt = s2_y_r;
            open_nxt  = 1'b1;
            vis_nxt   = (cls_r != 3'd0);
            if (cls_r != 3'd0) begin
              s3_v_nxt      = 1'b1;
              s3_hdr_nxt    = (s2_req_r == REQ_BEGIN_LINE) ? BYTE_LINE : BYTE_POLY;
              s3_cnt_nxt    = 3'd2;
              s3_val_nxt[0] = sx_ext;
              s3_val_nxt[1] = sy_ext;
            end
          end
          REQ_PEN: begin
            cls_nxt       = s2_pen_r;
            s3_v_nxt      = 1'b1;
            s3_hdr_nxt    = BYTE_PEN;
            s3_cnt_nxt    = 3'd2;
            s3_val_nxt[0] = NW'(pen_code(s2_pen_r));
            s3_trl_nxt    = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      cls_r   <= 3'd0;
      open_r  <= 1'b0;
      vis_r   <= 1'b0;
      s3_v_r  <= 1'b0;
    end else if (adv) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      cls_r   <= cls_nxt;
      open_r  <= open_nxt;
      vis_r   <= vis_nxt;
      s3_v_r  <= s3_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_first_r <= s3_first_nxt;
      s3_hdr_r   <= s3_hdr_nxt;
      s3_cnt_r   <= s3_cnt_nxt;
      s3_trl_r   <= s3_trl_nxt;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        s3_val_r[i] <= s3_val_nxt[i];
      end
    end
  end

  // Stage 4: saturate numbers and push the command
  always_comb begin
    q_data.first   = s3_first_r;
    q_data.hdr     = s3_hdr_r;
    q_data.num_cnt = s3_cnt_r;
    q_data.has_trl = s3_trl_r;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      q_data.nums[i] = sat_num(s3_val_r[i]);
    end
  end

  assign q_push = s3_v_r && !q_full;

endmodule
`default_nettype wire

@@ src/vpce_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module vpce_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vpce_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output vpce_pkg::cmd_t head,
  output logic           empty
);
  import vpce_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ src/vpce_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module vpce_back (
  input  logic           clk,
  input  logic           rst_n,
  input  vpce_pkg::cmd_t q_head,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast
);
  import vpce_pkg::*;

  logic       fresh_r;
  phase_t     ph_r, ph_nxt;
  logic [1:0] nidx_r, nidx_nxt;
  logic [1:0] didx_r, didx_nxt;
  logic       out_v_r;
  logic [7:0] out_b_r;
  logic       out_l_r;

  phase_t     ph;
  logic [1:0] ni;
  logic [1:0] di;
  logic       go;
  logic       done;
  num_t       cur;
  logic [1:0] top;
  logic [1:0] lvl;
  logic [7:0] byte_val;

  // A new command starts at the phase the front chose
  assign ph = fresh_r ? q_head.first : ph_r;
  assign ni = fresh_r ? 2'd0 : nidx_r;
  assign di = fresh_r ? 2'd0 : didx_r;

  // Emit a word when a command waits and the output slot frees up
  assign go = !q_empty && (!out_v_r || out_tready);

  // Number of prefix digits in the current number
  assign cur = q_head.nums[ni];
  always_comb begin
    if (cur.mag[21:16] != 6'd0) begin
      top = 2'd3;
    end else if (cur.mag[15:10] != 6'd0) begin
      top = 2'd2;
    end else if (cur.mag[9:4] != 6'd0) begin
      top = 2'd1;
    end else begin
      top = 2'd0;
    end
  end
  assign lvl = top - di;

  // Next position in the command
  always_comb begin
    ph_nxt   = ph;
    nidx_nxt = ni;
    didx_nxt = di;
    done     = 1'b0;
    unique case (ph)
      PH_HDR: begin
        if (q_head.num_cnt != 3'd0) begin
          ph_nxt   = PH_NUM;
          nidx_nxt = 2'd0;
          didx_nxt = 2'd0;
        end else if (q_head.has_trl) begin
          ph_nxt = PH_TRL;
        end else begin
          done = 1'b1;
        end
      end
      PH_NUM: begin
        if (di == top) begin
          if ({1'b0, ni} + 3'd1 == q_head.num_cnt) begin
            if (q_head.has_trl) begin
              ph_nxt = PH_TRL;
            end else begin
              done = 1'b1;
            end
          end else begin
            nidx_nxt = ni + 2'd1;
            didx_nxt = 2'd0;
          end
        end else begin
          didx_nxt = di + 2'd1;
        end
      end
      PH_TRL: begin
        done = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  // Word for the current position
  always_comb begin
    byte_val = BYTE_TERM;
    unique case (ph)
      PH_HDR: begin
        byte_val = q_head.hdr;
      end
      PH_NUM: begin
        case (lvl)
          2'd3:    byte_val = BYTE_PREFIX | {2'b00, cur.mag[21:16]};
          2'd2:    byte_val = BYTE_PREFIX | {2'b00, cur.mag[15:10]};
          2'd1:    byte_val = BYTE_PREFIX | {2'b00, cur.mag[9:4]};
          default: byte_val = (cur.neg ? BYTE_NUM_NEG : BYTE_NUM_POS) | {4'h0, cur.mag[3:0]};
        endcase
      end
      PH_TRL: begin
        byte_val = BYTE_TERM;
      end
      default: begin
        byte_val = BYTE_TERM;
      end
    endcase
  end

  assign q_pop = go && done;

  // Sequencer position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= 1'b1;
      ph_r    <= PH_HDR;
      nidx_r  <= 2'd0;
      didx_r  <= 2'd0;
    end else if (go) begin
      fresh_r <= done;
      ph_r    <= ph_nxt;
      nidx_r  <= nidx_nxt;
      didx_r  <= didx_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (go) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_b_r <= byte_val;
      out_l_r <= done;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_b_r;
  assign out_tlast  = out_l_r;

endmodule
`default_nettype wire

@@ src/vector_plot_command_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Vector plot command encoder: takes one plotting event per word on the in_ stream
// (req_type on in_tuser; x, y and pen class on in_tdata) and sends the printer vector
// command stream one byte per word on the out_ stream, with tlast on the last byte of
// each event. Coordinates are scaled by cfg_wdata / 2^SCALE_FRAC_BITS (write only
// while idle). Events enter through a three-stage front (multiply, truncate and clamp,
// pen state) at one per cycle unless held by a full queue; numbers are saturated on the
// way into a four-entry command queue, and the back sequencer sends one byte per cycle
// while out_tready allows. A move yields 0 bytes, a path event 1 to 9, a pen change 5
// and a draw 6 to 18; events with no bytes pass at one per cycle while the front is not
// held. An event's first byte goes through the front stages, queue and output register.
module vector_plot_command_encoder #(
  parameter int COORD_BITS      = vpce_pkg::COORD_BITS_DEF,
  parameter int SCALE_FRAC_BITS = vpce_pkg::SCALE_FRAC_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [vpce_pkg::SCALE_W-1:0]       cfg_wdata,   // scale_q10
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // x_coord, y_coord, pen_class, zero pad
  input  logic [((2*COORD_BITS+3+7)/8)*8-1:0] in_tdata,
  input  logic [2:0]                         in_tuser,    // req_type
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,   // out_byte
  output logic                               out_tlast    // last_byte
);
  import vpce_pkg::*;

  logic signed [COORD_BITS-1:0] in_x;
  logic signed [COORD_BITS-1:0] in_y;
  logic [2:0]                   in_pen;
  logic                         q_push;
  logic                         q_pop;
  logic                         q_full;
  logic                         q_empty;
  cmd_t                         q_wdata;
  cmd_t                         q_head;

  // Unpack the input word
  assign in_x   = in_tdata[COORD_BITS-1:0];
  assign in_y   = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_pen = in_tdata[2*COORD_BITS+2:2*COORD_BITS];

  vpce_front #(
    .COORD_BITS      (COORD_BITS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_tuser),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_pen    (in_pen),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  vpce_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  vpce_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import vpce_pkg::*;

  localparam int COORD_W = COORD_BITS_DEF;
  localparam int TDATA_W = ((2*COORD_W+3+7)/8)*8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam logic [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  // Tracks pen position and path state, predicts the command bytes of each event
  class cmd_byte_tracker;
    int unsigned scale_q10;
    longint      pos_x;
    longint      pos_y;
    logic [2:0]  pen_cls;
    bit          path_open;
    bit          path_vis;
    bit [8:0]    byte_q[$];   // {last, byte}
    int          errors;
    int          pen_codes[8];

    function new();
      scale_q10 = SCALE_RESET;
      pos_x = 0;
      pos_y = 0;
      pen_cls = '0;
      path_open = 0;
      path_vis = 0;
      errors = 0;
      pen_codes = '{-29, -30, -31, -32, -41, -33, -34, -35};
    endfunction

    // Scale, truncate toward zero, clamp to the coordinate range
    function longint scale_coord(logic [COORD_W-1:0] raw);
      longint p, s, lim;
      lim = longint'(1) << (COORD_W-1);
      s = scale_q10;
      p = longint'($signed(raw)) * s;
      p = p / (longint'(1) << SCALE_FRAC_DEF);
      if (p > lim - 1) p = lim - 1;
      if (p < -lim) p = -lim;
      return p;
    endfunction

    function void put_byte(logic [7:0] b);
      byte_q.push_back({1'b0, b});
    endfunction

    // Signed nibble code: prefix chunks, then the sign-marked low nibble
    function void put_num(longint v);
      longint lim, mag;
      lim = MAG_MAX;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      mag = (v < 0) ? -v : v;
      if (mag >= 65536) put_byte(BYTE_PREFIX | 8'(mag >> 16));
      if (mag >= 1024)  put_byte(BYTE_PREFIX | 8'((mag >> 10) & 63));
      if (mag >= 16)    put_byte(BYTE_PREFIX | 8'((mag >> 4) & 63));
      put_byte(((v < 0) ? BYTE_NUM_NEG : BYTE_NUM_POS) | 8'(mag & 15));
    endfunction

    function void note_event(logic [2:0] req, logic [COORD_W-1:0] xr,
                             logic [COORD_W-1:0] yr, logic [2:0] pen);
      int first_idx;
      longint nx, ny;
      bit [8:0] tail;
      first_idx = byte_q.size();
      nx = scale_coord(xr);
      ny = scale_coord(yr);
      if (path_open) begin
        // Only points and the end count while a path is open
        if (req == REQ_POINT) begin
          if (path_vis) begin
            put_num(nx - pos_x);
            put_num(ny - pos_y);
          end
          pos_x = nx;
          pos_y = ny;
        end else if (req == REQ_END) begin
          if (path_vis) put_byte(BYTE_TERM);
          path_open = 0;
          path_vis = 0;
        end
      end else begin
        case (req)
          REQ_MOVE: begin
            pos_x = nx;
            pos_y = ny;
          end
          REQ_DRAW: begin
            if (pen_cls != 0) begin
              put_byte(BYTE_LINE);
              put_num(pos_x);
              put_num(pos_y);
              put_num(nx - pos_x);
              put_num(ny - pos_y);
              put_byte(BYTE_TERM);
            end
            pos_x = nx;
            pos_y = ny;
          end
          REQ_BEGIN_LINE, REQ_BEGIN_POLY: begin
            pos_x = nx;
            pos_y = ny;
            path_open = 1;
            path_vis = (pen_cls != 0);
            if (path_vis) begin
              put_byte((req == REQ_BEGIN_LINE) ? BYTE_LINE : BYTE_POLY);
              put_num(pos_x);
              put_num(pos_y);
            end
          end
          REQ_PEN: begin
            pen_cls = pen;
            put_byte(BYTE_PEN);
            put_num(pen_codes[pen]);
            put_num(0);
            put_byte(BYTE_TERM);
          end
          default: ;
        endcase
      end
      // Mark the final byte of this event
      if (byte_q.size() > first_idx) begin
        tail = byte_q.pop_back();
        tail[8] = 1'b1;
        byte_q.push_back(tail);
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      bit [8:0] want;
      if (byte_q.size() == 0) begin
        $error("unexpected word: out_tdata got %h out_tlast got %b", data, last);
        errors++;
        return;
      end
      want = byte_q.pop_front();
      if (data !== want[7:0]) begin
        $error("out_tdata expected %h got %h", want[7:0], data);
        errors++;
      end
      if (last !== want[8]) begin
        $error("out_tlast expected %b got %b", want[8], last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [SCALE_W-1:0]   cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata;
  logic [2:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;
  logic                 out_tlast;

  cmd_byte_tracker sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_left;
  bit  hold_req;
  int  cycle_count;

  vector_plot_command_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watch both channels
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_tvalid && in_tready)
        sb.note_event(in_tuser, in_tdata[COORD_W-1:0], in_tdata[2*COORD_W-1:COORD_W],
                      in_tdata[2*COORD_W+2:2*COORD_W]);
      if (out_tvalid && out_tready)
        sb.check_byte(out_tdata, out_tlast);
    end
  end

  // Offer one event and hold it until accepted
  task automatic send_event(input logic [2:0] req, input logic [COORD_W-1:0] xr,
                            input logic [COORD_W-1:0] yr, input logic [2:0] pen);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= TDATA_W'({pen, yr, xr});
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering until every predicted byte has arrived, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    // Let the monitor note the last accepted event first
    @(posedge clk);
    while (sb.byte_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [SCALE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.scale_q10 = val;
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] c;
    case ($urandom_range(9))
      0:       c = C_MIN;
      1:       c = C_MAX;
      2, 3, 4: c = COORD_W'($urandom);
      5:       c = '0;
      default: c = COORD_W'($urandom_range(8191) - 4096);
    endcase
    return c;
  endfunction

  // Mostly well-formed event sequences, some noise
  task automatic run_random(input int n_events);
    int count, kind, npts;
    logic [2:0] cls;
    count = 0;
    while (count < n_events) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        cls = ($urandom_range(99) < 85) ? 3'($urandom_range(1, 7)) : 3'd0;
        send_event(REQ_PEN, rand_coord(), rand_coord(), cls);
        count++;
      end else if (kind < 27) begin
        send_event(REQ_MOVE, rand_coord(), rand_coord(), 3'($urandom));
        count++;
      end else if (kind < 52) begin
        send_event(REQ_DRAW, rand_coord(), rand_coord(), 3'($urandom));
        count++;
      end else if (kind < 85) begin
        npts = $urandom_range(1, 6);
        send_event($urandom_range(1) ? REQ_BEGIN_LINE : REQ_BEGIN_POLY,
                   rand_coord(), rand_coord(), 3'($urandom));
        repeat (npts) send_event(REQ_POINT, rand_coord(), rand_coord(), 3'($urandom));
        send_event(REQ_END, rand_coord(), rand_coord(), 3'($urandom));
        count += npts + 2;
      end else begin
        send_event(3'($urandom), rand_coord(), rand_coord(), 3'($urandom));
        count++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 79;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: invisible pen, then visible drawing and paths at the extremes
    send_event(REQ_PEN, '0, '0, 3'd0);
    send_event(REQ_DRAW, COORD_W'(1000), COORD_W'(1000), 3'd0);
    send_event(REQ_BEGIN_LINE, COORD_W'(-7), COORD_W'(9), 3'd0);
    send_event(REQ_POINT, COORD_W'(300), COORD_W'(-300), 3'd0);
    send_event(REQ_END, '0, '0, 3'd0);
    send_event(REQ_PEN, '0, '0, 3'd3);
    send_event(REQ_MOVE, C_MIN, C_MIN, 3'd0);
    send_event(REQ_DRAW, C_MAX, C_MAX, 3'd7);
    send_event(REQ_DRAW, C_MIN, C_MAX, 3'd0);
    send_event(REQ_BEGIN_LINE, C_MAX, C_MIN, 3'd0);
    send_event(REQ_POINT, '0, '0, 3'd0);
    // Everything but point and end is dropped while the path is open
    send_event(REQ_MOVE, COORD_W'(12), COORD_W'(34), 3'd0);
    send_event(REQ_DRAW, COORD_W'(56), COORD_W'(78), 3'd0);
    send_event(REQ_BEGIN_POLY, COORD_W'(1), COORD_W'(2), 3'd0);
    send_event(REQ_PEN, '0, '0, 3'd7);
    send_event(REQ_UNUSED, C_MAX, C_MAX, 3'd7);
    send_event(REQ_POINT, C_MIN, C_MIN, 3'd0);
    send_event(REQ_END, '0, '0, 3'd0);
    // Point and end with no open path
    send_event(REQ_POINT, COORD_W'(5), COORD_W'(5), 3'd0);
    send_event(REQ_END, '0, '0, 3'd0);
    send_event(REQ_UNUSED, '0, '0, 3'd0);
    send_event(REQ_BEGIN_POLY, COORD_W'(5), COORD_W'(-5), 3'd0);
    send_event(REQ_POINT, COORD_W'(-100000), COORD_W'(2000), 3'd0);
    send_event(REQ_END, '0, '0, 3'd0);
    send_event(REQ_PEN, '0, '0, 3'd7);

    run_random(110);

    // Stall the receiver while long draws keep coming, so the queue backs up
    send_event(REQ_PEN, '0, '0, 3'd5);
    send_idle_pct = 0;
    hold_req = 1'b1;
    repeat (7) begin
      send_event(REQ_DRAW, C_MAX, C_MIN, 3'($urandom));
      send_event(REQ_DRAW, C_MIN, C_MAX, 3'($urandom));
    end
    send_idle_pct = 27;
    drain();

    // Zero scale collapses every point onto the origin
    cfg_write('0);
    run_random(20);
    drain();

    // Scale above unity drives points into the clamp
    cfg_write({SCALE_W{1'b1}});
    run_random(50);
    drain();

    send_idle_pct = 79;
    recv_idle_pct = 27;
    cfg_write(SCALE_W'(1));
    run_random(120);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(SCALE_W'(1024));
    run_random(60);
    drain();
    cfg_write(SCALE_W'($urandom_range(1, 1024)));
    run_random(60);
    drain();

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
